// ===== design/dfmrp_pkg.sv =====
package dfmrp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned EventW = 3;
  localparam int unsigned LevelW = 7;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  typedef enum logic [EventW-1:0] {
    EvNone   = 3'd0,
    EvAccept = 3'd1,
    EvReject = 3'd2,
    EvOk     = 3'd3,
    EvError  = 3'd4
  } event_e;

  localparam logic RegLinkReady = 1'b0;
  localparam logic RegNodeId    = 1'b1;

  localparam logic [ByteW-1:0] ChStart   = 8'h23;
  localparam logic [ByteW-1:0] ChEnd     = 8'h24;
  localparam logic [ByteW-1:0] ChPad     = 8'h30;
  localparam logic [ByteW-1:0] LevelLo   = 8'h8C;
  localparam logic [ByteW-1:0] LevelHi   = 8'hF0;
  localparam logic [ByteW-1:0] LevelBias = 8'd140;
  localparam logic [ByteW-1:0] ChO       = 8'h4F;
  localparam logic [ByteW-1:0] ChK       = 8'h4B;
  localparam logic [ByteW-1:0] ChE       = 8'h45;
  localparam logic [ByteW-1:0] ChR       = 8'h52;
  localparam logic [ByteW-1:0] ChCr      = 8'h0D;
  localparam logic [ByteW-1:0] ChLf      = 8'h0A;

  localparam logic [ByteW-1:0] NodeIdReset = 8'h4C;

endpackage

// ===== design/dfmrp_in_if.sv =====
interface dfmrp_in_if;
  logic                            valid;
  logic                            ready;
  logic [dfmrp_pkg::ByteW-1:0]     rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/dfmrp_out_if.sv =====
interface dfmrp_out_if;
  logic                            valid;
  logic                            ready;
  logic [dfmrp_pkg::EventW-1:0]    event_res;
  logic [dfmrp_pkg::LevelW-1:0]    level;

  modport source (output valid, output event_res, output level, input ready);
  modport sink (input valid, input event_res, input level, output ready);
endinterface

// ===== design/dimmer_frame_and_modem_reply_parser.sv =====
// An accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle unless the output stalls; both registers carry the work.
// The result register frees in the cycle its transfer completes, so stalls cost no bubbles.
// Reset clears both parsers to their idle phases, empties both registers,
// and sets link_ready to 0 and node_id to ASCII L.
module dimmer_frame_and_modem_reply_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dfmrp_in_if.sink                      in_i,
  dfmrp_out_if.source                   out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfmrp_pkg::AddrW-1:0]   paddr,
  input  logic [dfmrp_pkg::DataW-1:0]   pwdata,
  output logic [dfmrp_pkg::DataW-1:0]   prdata,
  output logic                          pready
);

  localparam logic [dfmrp_pkg::PhaseW-1:0] FrWait  = 3'd0;
  localparam logic [dfmrp_pkg::PhaseW-1:0] FrNode  = 3'd1;
  localparam logic [dfmrp_pkg::PhaseW-1:0] FrLevel = 3'd2;
  localparam logic [dfmrp_pkg::PhaseW-1:0] FrPad   = 3'd3;
  localparam logic [dfmrp_pkg::PhaseW-1:0] FrSum   = 3'd4;
  localparam logic [dfmrp_pkg::PhaseW-1:0] FrEnd   = 3'd5;

  localparam logic [dfmrp_pkg::PhaseW-1:0] RpIdle = 3'd0;
  localparam logic [dfmrp_pkg::PhaseW-1:0] RpE    = 3'd1;
  localparam logic [dfmrp_pkg::PhaseW-1:0] RpEr   = 3'd2;
  localparam logic [dfmrp_pkg::PhaseW-1:0] RpErr  = 3'd3;
  localparam logic [dfmrp_pkg::PhaseW-1:0] RpErro = 3'd4;
  localparam logic [dfmrp_pkg::PhaseW-1:0] RpO    = 3'd5;
  localparam logic [dfmrp_pkg::PhaseW-1:0] RpOk   = 3'd6;
  localparam logic [dfmrp_pkg::PhaseW-1:0] RpOkCr = 3'd7;

  logic                            link_ready_q;
  logic [dfmrp_pkg::ByteW-1:0]     node_id_q;
  logic                            cfg_wr;

  logic                            s1_valid_q;
  logic [dfmrp_pkg::ByteW-1:0]     s1_byte_q;
  logic                            s2_take;
  logic                            in_fire;

  logic [dfmrp_pkg::PhaseW-1:0]    frame_phase_q, frame_phase_d;
  logic [dfmrp_pkg::ByteW-1:0]     held_q, held_d;
  logic [dfmrp_pkg::PhaseW-1:0]    reply_phase_q, reply_phase_d;

  dfmrp_pkg::event_e               ev_d;
  logic [dfmrp_pkg::LevelW-1:0]    lvl_d;
  logic [dfmrp_pkg::ByteW-1:0]     lvl_full;
  logic [dfmrp_pkg::ByteW-1:0]     sum_exp;

  logic                            out_valid_q;
  logic [dfmrp_pkg::EventW-1:0]    out_event_q;
  logic [dfmrp_pkg::LevelW-1:0]    out_level_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      dfmrp_pkg::RegLinkReady: prdata[0] = link_ready_q;
      dfmrp_pkg::RegNodeId:    prdata[dfmrp_pkg::ByteW-1:0] = node_id_q;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_ready_q <= 1'b0;
      node_id_q    <= dfmrp_pkg::NodeIdReset;
    end else if (cfg_wr) begin
      if (paddr[2] == dfmrp_pkg::RegLinkReady) begin
        link_ready_q <= pwdata[0];
      end else begin
        node_id_q <= pwdata[dfmrp_pkg::ByteW-1:0];
      end
    end
  end

  assign s2_take  = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s2_take;
  assign in_fire  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_i.rx_byte;
    end
  end

  assign lvl_full = held_q - dfmrp_pkg::LevelBias;
  assign sum_exp  = held_q + dfmrp_pkg::ChPad;

  always_comb begin
    frame_phase_d = frame_phase_q;
    held_d        = held_q;
    reply_phase_d = reply_phase_q;
    ev_d          = dfmrp_pkg::EvNone;
    lvl_d         = '0;
    if (link_ready_q) begin
      unique case (frame_phase_q)
        FrNode: begin
          frame_phase_d = (s1_byte_q == node_id_q) ? FrLevel : FrWait;
        end
        FrLevel: begin
          if (s1_byte_q >= dfmrp_pkg::LevelLo && s1_byte_q <= dfmrp_pkg::LevelHi) begin
            held_d        = s1_byte_q;
            frame_phase_d = FrPad;
          end else begin
            frame_phase_d = FrWait;
            ev_d          = dfmrp_pkg::EvReject;
          end
        end
        FrPad: begin
          if (s1_byte_q == dfmrp_pkg::ChPad) begin
            frame_phase_d = FrSum;
          end else begin
            frame_phase_d = FrWait;
            ev_d          = dfmrp_pkg::EvReject;
          end
        end
        FrSum: begin
          if (s1_byte_q == sum_exp) begin
            frame_phase_d = FrEnd;
          end else begin
            frame_phase_d = FrWait;
            ev_d          = dfmrp_pkg::EvReject;
          end
        end
        FrEnd: begin
          frame_phase_d = FrWait;
          if (s1_byte_q == dfmrp_pkg::ChEnd) begin
            ev_d  = dfmrp_pkg::EvAccept;
            lvl_d = lvl_full[dfmrp_pkg::LevelW-1:0];
          end else begin
            ev_d = dfmrp_pkg::EvReject;
          end
        end
        default: begin
          frame_phase_d = (s1_byte_q == dfmrp_pkg::ChStart) ? FrNode : FrWait;
        end
      endcase
    end else begin
      unique case (reply_phase_q)
        RpIdle: begin
          if (s1_byte_q == dfmrp_pkg::ChO) begin
            reply_phase_d = RpO;
          end else if (s1_byte_q == dfmrp_pkg::ChE) begin
            reply_phase_d = RpE;
          end
        end
        RpE:    reply_phase_d = (s1_byte_q == dfmrp_pkg::ChR) ? RpEr : RpIdle;
        RpEr:   reply_phase_d = (s1_byte_q == dfmrp_pkg::ChR) ? RpErr : RpIdle;
        RpErr:  reply_phase_d = (s1_byte_q == dfmrp_pkg::ChO) ? RpErro : RpIdle;
        RpErro: begin
          reply_phase_d = RpIdle;
          if (s1_byte_q == dfmrp_pkg::ChR) begin
            ev_d = dfmrp_pkg::EvError;
          end
        end
        RpO:    reply_phase_d = (s1_byte_q == dfmrp_pkg::ChK) ? RpOk : RpIdle;
        RpOk:   reply_phase_d = (s1_byte_q == dfmrp_pkg::ChCr) ? RpOkCr : RpIdle;
        default: begin
          reply_phase_d = RpIdle;
          if (s1_byte_q == dfmrp_pkg::ChLf) begin
            ev_d = dfmrp_pkg::EvOk;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_phase_q <= FrWait;
      held_q        <= '0;
      reply_phase_q <= RpIdle;
      out_valid_q   <= 1'b0;
    end else if (s2_take) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        frame_phase_q <= frame_phase_d;
        held_q        <= held_d;
        reply_phase_q <= reply_phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_take && s1_valid_q) begin
      out_event_q <= ev_d;
      out_level_q <= lvl_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = out_event_q;
  assign out_o.level     = out_level_q;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_event_q == dfmrp_pkg::EvAccept |-> out_level_q <= 7'd100)
    else $error("accepted frame level out of range");

  a_level_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_event_q != dfmrp_pkg::EvAccept |-> out_level_q == '0)
    else $error("level set on a result other than an accepted frame");

  a_frame_phase_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_phase_q <= FrEnd)
    else $error("frame parser in an unused phase");

  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled while the result register is empty");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_take |=> out_valid_q)
    else $error("held byte produced no result");

endmodule

// ===== tb/tb_dimmer_frame_and_modem_reply_parser.sv =====
`timescale 1ns / 1ps

module tb_dimmer_frame_and_modem_reply_parser;

  localparam int unsigned ByteW  = dfmrp_pkg::ByteW;
  localparam int unsigned AddrW  = dfmrp_pkg::AddrW;
  localparam int unsigned DataW  = dfmrp_pkg::DataW;
  localparam int unsigned LevelW = dfmrp_pkg::LevelW;
  localparam int unsigned PhaseW = dfmrp_pkg::PhaseW;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SegmentCount = 12;
  localparam int unsigned SegmentBytes = 142;

  localparam logic [AddrW-1:0] AddrLinkReady = AddrW'(4 * dfmrp_pkg::RegLinkReady);
  localparam logic [AddrW-1:0] AddrNodeId    = AddrW'(4 * dfmrp_pkg::RegNodeId);

  typedef enum logic [PhaseW-1:0] {
    FrmIdle  = 3'd0,
    FrmNode  = 3'd1,
    FrmLevel = 3'd2,
    FrmPad   = 3'd3,
    FrmSum   = 3'd4,
    FrmEnd   = 3'd5
  } frame_phase_e;

  typedef enum logic [PhaseW-1:0] {
    RpIdle = 3'd0,
    RpE    = 3'd1,
    RpEr   = 3'd2,
    RpErr  = 3'd3,
    RpErro = 3'd4,
    RpO    = 3'd5,
    RpOk   = 3'd6,
    RpOkCr = 3'd7
  } reply_phase_e;

  typedef struct packed {
    dfmrp_pkg::event_e ev;
    logic [LevelW-1:0] lvl;
  } parse_result_t;

  logic             clk;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  dfmrp_in_if  in_if ();
  dfmrp_out_if out_if ();

  dimmer_frame_and_modem_reply_parser DUT (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic             cfg_link;
  logic [ByteW-1:0] cfg_node;
  frame_phase_e     frm_phase;
  logic [ByteW-1:0] frm_level_byte;
  reply_phase_e     rpl_phase;

  logic [ByteW-1:0] rx_stream[$];
  parse_result_t    expected_events[$];

  bit          in_busy;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned errors;
  int unsigned bytes_queued;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned cycle_cnt;
  int unsigned settings_cnt;
  int unsigned n_accept;
  int unsigned n_reject;
  int unsigned n_ok;
  int unsigned n_error;

  function automatic parse_result_t parse_byte(input logic [ByteW-1:0] b);
    parse_result_t    r;
    logic [ByteW-1:0] sum;
    r.ev  = dfmrp_pkg::EvNone;
    r.lvl = '0;
    if (cfg_link) begin
      case (frm_phase)
        FrmNode: begin
          frm_phase = (b == cfg_node) ? FrmLevel : FrmIdle;
        end
        FrmLevel: begin
          if (b >= dfmrp_pkg::LevelLo && b <= dfmrp_pkg::LevelHi) begin
            frm_level_byte = b;
            frm_phase      = FrmPad;
          end else begin
            frm_phase = FrmIdle;
            r.ev      = dfmrp_pkg::EvReject;
          end
        end
        FrmPad: begin
          if (b == dfmrp_pkg::ChPad) begin
            frm_phase = FrmSum;
          end else begin
            frm_phase = FrmIdle;
            r.ev      = dfmrp_pkg::EvReject;
          end
        end
        FrmSum: begin
          sum = frm_level_byte + dfmrp_pkg::ChPad;
          if (b == sum) begin
            frm_phase = FrmEnd;
          end else begin
            frm_phase = FrmIdle;
            r.ev      = dfmrp_pkg::EvReject;
          end
        end
        FrmEnd: begin
          frm_phase = FrmIdle;
          if (b == dfmrp_pkg::ChEnd) begin
            r.ev  = dfmrp_pkg::EvAccept;
            r.lvl = LevelW'(frm_level_byte - dfmrp_pkg::LevelBias);
          end else begin
            r.ev = dfmrp_pkg::EvReject;
          end
        end
        default: begin
          frm_phase = (b == dfmrp_pkg::ChStart) ? FrmNode : FrmIdle;
        end
      endcase
    end else begin
      case (rpl_phase)
        RpIdle: begin
          if (b == dfmrp_pkg::ChO) begin
            rpl_phase = RpO;
          end else if (b == dfmrp_pkg::ChE) begin
            rpl_phase = RpE;
          end
        end
        RpE:   rpl_phase = (b == dfmrp_pkg::ChR) ? RpEr : RpIdle;
        RpEr:  rpl_phase = (b == dfmrp_pkg::ChR) ? RpErr : RpIdle;
        RpErr: rpl_phase = (b == dfmrp_pkg::ChO) ? RpErro : RpIdle;
        RpErro: begin
          if (b == dfmrp_pkg::ChR) begin
            r.ev = dfmrp_pkg::EvError;
          end
          rpl_phase = RpIdle;
        end
        RpO:  rpl_phase = (b == dfmrp_pkg::ChK) ? RpOk : RpIdle;
        RpOk: rpl_phase = (b == dfmrp_pkg::ChCr) ? RpOkCr : RpIdle;
        default: begin
          if (b == dfmrp_pkg::ChLf) begin
            r.ev = dfmrp_pkg::EvOk;
          end
          rpl_phase = RpIdle;
        end
      endcase
    end
    return r;
  endfunction

  function automatic void feed(input logic [ByteW-1:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endfunction

  // A reply text, cut after its first n characters, with one character flipped at bad_pos.
  task automatic queue_text(input string txt, input int n, input int bad_pos);
    logic [ByteW-1:0] b;
    for (int i = 0; i < n; i++) begin
      b = txt[i];
      if (i == bad_pos) begin
        b = b ^ ByteW'($urandom_range(255, 1));
      end
      feed(b);
    end
  endtask

  task automatic queue_frame(input logic [ByteW-1:0] node, input logic [ByteW-1:0] lvl_b,
                             input int bad_pos);
    logic [ByteW-1:0] frm[6];
    frm[0] = dfmrp_pkg::ChStart;
    frm[1] = node;
    frm[2] = lvl_b;
    frm[3] = dfmrp_pkg::ChPad;
    frm[4] = lvl_b + dfmrp_pkg::ChPad;
    frm[5] = dfmrp_pkg::ChEnd;
    for (int i = 0; i < 6; i++) begin
      if (i == bad_pos) begin
        frm[i] = frm[i] ^ ByteW'($urandom_range(255, 1));
      end
      feed(frm[i]);
    end
  endtask

  task automatic wait_idle();
    while (rx_stream.size() != 0 || in_busy || expected_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Write a register, then read it back and compare with the masked value.
  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    logic [DataW-1:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == AddrLinkReady) begin
      cfg_link = data[0];
      want     = DataW'(cfg_link);
    end else begin
      cfg_node = data[ByteW-1:0];
      want     = DataW'(cfg_node);
    end
    settings_cnt++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      errors++;
      $display("%0t: register readback at %0d, expected %0h, got %0h",
               $time, addr, want, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    if (!in_busy) begin
      if (rx_stream.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_if.rx_byte <= rx_stream.pop_front();
        in_if.valid   <= 1'b1;
        in_busy = 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    parse_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got event %0d level %0d",
                   $time, out_if.event_res, out_if.level);
        end else begin
          want = expected_events.pop_front();
          if (out_if.event_res !== want.ev || out_if.level !== want.lvl) begin
            errors++;
            $display("%0t: result mismatch, expected event %0d level %0d, got event %0d level %0d",
                     $time, want.ev, want.lvl, out_if.event_res, out_if.level);
          end
          case (want.ev)
            dfmrp_pkg::EvAccept: n_accept++;
            dfmrp_pkg::EvReject: n_reject++;
            dfmrp_pkg::EvOk:     n_ok++;
            dfmrp_pkg::EvError:  n_error++;
            default: ;
          endcase
        end
      end
      if (in_if.valid && in_if.ready) begin
        expected_events.push_back(parse_byte(in_if.rx_byte));
        bytes_sent++;
        in_busy = 1'b0;
      end
    end
  end

  initial begin
    int unsigned      pick;
    int unsigned      seg_start;
    int               cut;
    int               bad;
    logic [ByteW-1:0] node_pick;
    logic [ByteW-1:0] lvl_b;
    string            txt;

    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.rx_byte  = '0;
    out_if.ready   = 1'b0;
    cfg_link       = 1'b0;
    cfg_node       = dfmrp_pkg::NodeIdReset;
    frm_phase      = FrmIdle;
    frm_level_byte = '0;
    rpl_phase      = RpIdle;
    src_idle_pct   = 9;
    sink_stall_pct = 79;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // The replies, a broken start that is not looked at again, and a bad final character.
    queue_text("OK\r\n", 4, -1);
    queue_text("ERROR", 5, -1);
    queue_text("OERR", 4, -1);
    queue_text("OK\rE", 4, -1);
    wait_idle();
    write_reg(AddrLinkReady, 32'hFFFF_FFFF);
    queue_frame(dfmrp_pkg::NodeIdReset, dfmrp_pkg::LevelLo, -1);
    queue_frame(dfmrp_pkg::NodeIdReset, dfmrp_pkg::LevelHi, -1);
    queue_frame(dfmrp_pkg::NodeIdReset, 8'hB4, 4);
    queue_frame(dfmrp_pkg::NodeIdReset, 8'hB4, 5);
    queue_frame(dfmrp_pkg::NodeIdReset, dfmrp_pkg::LevelLo - 8'd1, -1);
    queue_frame(dfmrp_pkg::NodeIdReset, dfmrp_pkg::LevelHi + 8'd1, -1);

    // Each parser keeps its place while the other mode is selected.
    feed(dfmrp_pkg::ChStart);
    feed(dfmrp_pkg::NodeIdReset);
    wait_idle();
    write_reg(AddrLinkReady, 32'h0000_0000);
    queue_text("OK", 2, -1);
    wait_idle();
    write_reg(AddrLinkReady, 32'h0000_0001);
    feed(8'hC8);
    feed(dfmrp_pkg::ChPad);
    feed(8'hC8 + dfmrp_pkg::ChPad);
    feed(dfmrp_pkg::ChEnd);
    wait_idle();
    write_reg(AddrLinkReady, 32'h0000_0000);
    queue_text("\r\n", 2, -1);

    for (int seg = 0; seg < SegmentCount; seg++) begin
      wait_idle();
      if (seg < 4) begin
        src_idle_pct   = 9;
        sink_stall_pct = 79;
      end else if (seg < 8) begin
        src_idle_pct   = 79;
        sink_stall_pct = 9;
      end else begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      case (seg % 3)
        0:       node_pick = 8'h00;
        1:       node_pick = 8'hFF;
        default: node_pick = ByteW'($urandom);
      endcase
      write_reg(AddrNodeId, ($urandom & 32'hFFFF_FF00) | DataW'(node_pick));
      write_reg(AddrLinkReady, ($urandom & 32'hFFFF_FFFE) | DataW'(seg % 4 != 1));
      seg_start = bytes_queued;
      while (bytes_queued - seg_start < SegmentBytes) begin
        pick = $urandom_range(99);
        if (cfg_link) begin
          lvl_b = ByteW'($urandom_range(dfmrp_pkg::LevelHi, dfmrp_pkg::LevelLo));
          if ($urandom_range(9) == 0) begin
            lvl_b = $urandom_range(1) ? dfmrp_pkg::LevelLo : dfmrp_pkg::LevelHi;
          end
          if (pick < 60) begin
            queue_frame(cfg_node, lvl_b, -1);
          end else if (pick < 75) begin
            queue_frame(cfg_node, lvl_b, $urandom_range(5, 1));
          end else if (pick < 85) begin
            queue_frame(cfg_node, ByteW'($urandom), -1);
          end else if (pick < 92) begin
            feed(dfmrp_pkg::ChStart);
          end else begin
            feed(ByteW'($urandom));
          end
        end else begin
          if ($urandom_range(1)) begin
            txt = "OK\r\n";
          end else begin
            txt = "ERROR";
          end
          if (pick < 60) begin
            queue_text(txt, txt.len(), -1);
          end else if (pick < 85) begin
            cut = $urandom_range(txt.len(), 1);
            bad = -1;
            if ($urandom_range(1)) begin
              bad = $urandom_range(cut - 1);
            end
            queue_text(txt, cut, bad);
          end else begin
            feed(ByteW'($urandom));
          end
        end
      end
      // Leave a frame or a reply half done across the next register change.
      if (cfg_link) begin
        feed(dfmrp_pkg::ChStart);
        feed(cfg_node);
      end else begin
        feed(dfmrp_pkg::ChO);
      end
    end

    wait_idle();
    $display("Checked %0d results for %0d bytes across %0d register writes.",
             results_seen, bytes_sent, settings_cnt);
    $display("Seen: %0d frames accepted, %0d rejected, %0d OK and %0d ERROR replies.",
             n_accept, n_reject, n_ok, n_error);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
